>>> design/fba_pkg.sv
// Shared types, constants and helpers of the frame bitmap allocator.
package fba_pkg;

   localparam int FRAME_W        = 12;
   localparam int CFG_W          = 13;
   localparam int WORD_BITS      = 32;
   localparam int BIT_W          = 5;
   localparam int SCAN_W         = CFG_W - BIT_W;
   localparam int DEF_MAX_FRAMES = 4096;
   localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NOTHING  = 2'd1,
      ST_NO_FREE  = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   // Lowest clear bit of a word; caller checks that one exists.
   function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!w[i]) idx = BIT_W'(i);
      end
      return idx;
   endfunction

endpackage

>>> design/frame_bitmap_allocator.sv
// Frame bitmap allocator: first-fit page frame allocation over a word-wide bitmap memory.
//
// Keeps one used bit per physical frame in a memory of MAX_FRAMES/32 words of 32 bits.
// After reset a clearing pass writes one word a cycle through the whole memory; no request
// is taken during it, configuration writes are. An allocate request for a page that holds
// no frame scans the words from the lowest up through one memory read port and one
// find-first-zero unit, one word a cycle, and stops at the first word with a clear bit or
// after the last of the frames_in_use/32 words. A free is a read-modify-write of one word.
// One request is in work at a time; the result waits in an output register, so the next
// request is taken while it is unclaimed. req_tdata: [11:0] page_frame, [12] kernel_page,
// [13] writable_page. rsp_tdata: [11:0] granted_frame, [12] present_bit, [13] rw_bit,
// [14] user_bit, [16:15] status.
module frame_bitmap_allocator #(
   parameter int MAX_FRAMES = fba_pkg::DEF_MAX_FRAMES
) (
   input  logic                            clock,
   input  logic                            reset,
   // tuser: [0] req_type
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fba_pkg::REQ_DATA_W-1:0]  req_tdata,   // [11:0] page_frame, [12] kernel_page, [13] writable_page
   input  logic                            req_tuser,   // [0] req_type
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fba_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [11:0] granted_frame, [12] present_bit,
                                                        // [13] rw_bit, [14] user_bit, [16:15] status
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fba_pkg::CFG_W-1:0]       csr_data     // frames_in_use
);
   import fba_pkg::*;

   localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_SCAN, S_FREE_RD, S_FREE_WR, S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [SCAN_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic [SCAN_W-1:0]      chk_cnt_ff, chk_cnt_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [SCAN_W-1:0]      words_ff, words_in;
   logic [FRAME_W-1:0]     pf_ff, pf_in;
   logic                   kern_ff, kern_in;
   logic                   wr_ff, wr_in;
   logic [FRAME_W-1:0]     res_frame_ff, res_frame_in;
   logic                   res_present_ff, res_present_in;
   logic                   res_rw_ff, res_rw_in;
   logic                   res_user_ff, res_user_in;
   status_type             res_status_ff, res_status_in;
   logic [RSP_DATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [CFG_W-1:0]       cfg_ff;

   logic [WORD_BITS-1:0]   mem [MAP_WORDS];
   logic [WORD_BITS-1:0]   mem_rd_ff;
   logic                   mem_re, mem_we;
   logic [AW-1:0]          mem_ra, mem_wa;
   logic [WORD_BITS-1:0]   mem_wd;

   logic [CFG_W-1:0]       limit;
   logic [FRAME_W-1:0]     in_pf;
   logic [BIT_W-1:0]       free_bit;
   logic                   found;

   assign in_pf    = req_tdata[FRAME_W-1:0];
   assign limit    = (32'(cfg_ff) > MAX_FRAMES) ? CFG_W'(MAX_FRAMES) : cfg_ff;
   assign free_bit = first_zero(mem_rd_ff);
   assign found    = chk_vld_ff && (mem_rd_ff != '1);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) mem_rd_ff <= mem[mem_ra];
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      rd_cnt_in      = rd_cnt_ff;
      chk_cnt_in     = chk_cnt_ff;
      chk_vld_in     = chk_vld_ff;
      words_in       = words_ff;
      pf_in          = pf_ff;
      kern_in        = kern_ff;
      wr_in          = wr_ff;
      res_frame_in   = res_frame_ff;
      res_present_in = res_present_ff;
      res_rw_in      = res_rw_ff;
      res_user_in    = res_user_ff;
      res_status_in  = res_status_ff;
      rsp_tdata_in   = rsp_tdata_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      mem_re         = 1'b0;
      mem_we         = 1'b0;
      mem_ra         = AW'(rd_cnt_ff);
      mem_wa         = AW'(chk_cnt_ff);
      mem_wd         = mem_rd_ff | (WORD_BITS'(1) << free_bit);

      if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_in = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               pf_in          = in_pf;
               kern_in        = req_tdata[FRAME_W];
               wr_in          = req_tdata[FRAME_W+1];
               res_frame_in   = in_pf;
               res_present_in = 1'b0;
               res_rw_in      = 1'b0;
               res_user_in    = 1'b0;
               res_status_in  = ST_DONE;
               if (req_tuser == REQ_ALLOC) begin
                  if (in_pf != '0) begin
                     res_status_in = ST_NOTHING;
                     state_in      = S_DONE;
                  end else begin
                     rd_cnt_in  = '0;
                     chk_vld_in = 1'b0;
                     words_in   = limit[CFG_W-1:BIT_W];
                     state_in   = S_SCAN;
                  end
               end else begin
                  if (in_pf == '0) begin
                     res_status_in = ST_NOTHING;
                     state_in      = S_DONE;
                  end else if ({1'b0, in_pf} >= limit) begin
                     res_status_in = ST_RANGE;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_FREE_RD;
                  end
               end
            end
         end
         S_SCAN: begin
            if (found) begin
               // mark the frame used in the word just checked
               mem_we         = 1'b1;
               res_frame_in   = {chk_cnt_ff[FRAME_W-BIT_W-1:0], free_bit};
               res_present_in = 1'b1;
               res_rw_in      = wr_ff;
               res_user_in    = ~kern_ff;
               state_in       = S_DONE;
            end else if (rd_cnt_ff < words_ff) begin
               mem_re     = 1'b1;
               chk_cnt_in = rd_cnt_ff;
               chk_vld_in = 1'b1;
               rd_cnt_in  = rd_cnt_ff + SCAN_W'(1);
            end else begin
               res_frame_in  = '0;
               res_status_in = ST_NO_FREE;
               state_in      = S_DONE;
            end
         end
         S_FREE_RD: begin
            mem_re   = 1'b1;
            mem_ra   = AW'(pf_ff[FRAME_W-1:BIT_W]);
            state_in = S_FREE_WR;
         end
         S_FREE_WR: begin
            mem_we       = 1'b1;
            mem_wa       = AW'(pf_ff[FRAME_W-1:BIT_W]);
            mem_wd       = mem_rd_ff & ~(WORD_BITS'(1) << pf_ff[BIT_W-1:0]);
            res_frame_in = '0;
            state_in     = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tdata_in  = {7'b0, res_status_ff, res_user_ff, res_rw_ff,
                                res_present_ff, res_frame_ff};
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         clr_ff        <= '0;
         chk_vld_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         cfg_ff        <= CFG_RESET;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid) cfg_ff <= csr_data;
      end
      rd_cnt_ff      <= rd_cnt_in;
      chk_cnt_ff     <= chk_cnt_in;
      words_ff       <= words_in;
      pf_ff          <= pf_in;
      kern_ff        <= kern_in;
      wr_ff          <= wr_in;
      res_frame_ff   <= res_frame_in;
      res_present_ff <= res_present_in;
      res_rw_ff      <= res_rw_in;
      res_user_ff    <= res_user_in;
      res_status_ff  <= res_status_in;
      rsp_tdata_ff   <= rsp_tdata_in;
   end

endmodule

>>> design/fba_checker.sv
// Port-level checks of the frame bitmap allocator, bound to the top level.
module fba_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [fba_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import fba_pkg::*;

   logic [1:0] rsp_status;
   assign rsp_status = rsp_tdata[16:15];

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // one request in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in work");

   a_present_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12] |-> rsp_status == ST_DONE)
      else $error("present flag on a failed request");

   a_flags_clear_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status != ST_DONE |-> rsp_tdata[14:12] == 3'b000)
      else $error("entry flags set on a failed request");

   a_no_free_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == ST_NO_FREE |-> rsp_tdata[11:0] == 12'd0)
      else $error("frame nonzero with no free frame");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the frame bitmap allocator: directed table, then random phases.
module testbench;
   import fba_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 150;
   localparam int N_ROWS         = 24;
   localparam int N_PHASES       = 6;

   typedef struct packed {
      status_type       status;
      logic             user;
      logic             rw;
      logic             present;
      logic [FRAME_W-1:0] frame;
   } page_entry_type;

   typedef enum logic {
      ROW_REQ = 1'b0,
      ROW_CSR = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [CFG_W-1:0]   csr_value;
      req_kind_type       req;
      logic [FRAME_W-1:0] frame;
      logic               kern;
      logic               wr;
      logic               known;
      page_entry_type     typed_entry;
   } dir_row_type;

   typedef struct packed {
      logic [CFG_W-1:0] frames;
      int               send_idle;
      int               recv_idle;
      int               items;
      int               alloc_pct;
   } phase_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;   // [11:0] page_frame, [12] kernel_page, [13] writable_page
   logic                   req_tuser;   // [0] req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;   // [11:0] granted_frame, [12] present_bit, [13] rw_bit,
                                        // [14] user_bit, [16:15] status
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CFG_W-1:0]       csr_data;    // frames_in_use

   // allocator state as the block should hold it
   bit                 frame_used [0:DEF_MAX_FRAMES-1];
   logic [CFG_W-1:0]   frames_setting;
   logic [FRAME_W-1:0] held_frames [$];
   page_entry_type     awaited_entries [$];

   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_request;
   int  mismatches = 0;
   int  idle_cycles = 0;
   int  requests_sent;
   int  settings_used;
   int  status_seen [4];

   dir_row_type dir_rows [N_ROWS] = '{
      // frame zero is granted first
      '{ROW_REQ, 13'd0, REQ_ALLOC, 12'd0, 1'b1, 1'b0, 1'b1, '{ST_DONE, 1'b0, 1'b0, 1'b1, 12'd0}},
      '{ROW_REQ, 13'd0, REQ_ALLOC, 12'd0, 1'b0, 1'b1, 1'b1, '{ST_DONE, 1'b1, 1'b1, 1'b1, 12'd1}},
      '{ROW_REQ, 13'd0, REQ_ALLOC, 12'd4095, 1'b1, 1'b1, 1'b1,
        '{ST_NOTHING, 1'b0, 1'b0, 1'b0, 12'd4095}},
      '{ROW_REQ, 13'd0, REQ_FREE, 12'd0, 1'b0, 1'b0, 1'b1,
        '{ST_NOTHING, 1'b0, 1'b0, 1'b0, 12'd0}},
      '{ROW_REQ, 13'd0, REQ_FREE, 12'd1, 1'b1, 1'b1, 1'b1, '{ST_DONE, 1'b0, 1'b0, 1'b0, 12'd0}},
      '{ROW_REQ, 13'd0, REQ_ALLOC, 12'd0, 1'b0, 1'b0, 1'b1, '{ST_DONE, 1'b1, 1'b0, 1'b1, 12'd1}},
      // release of a frame that is already free still succeeds
      '{ROW_REQ, 13'd0, REQ_FREE, 12'd4095, 1'b0, 1'b1, 1'b1,
        '{ST_DONE, 1'b0, 1'b0, 1'b0, 12'd0}},
      '{ROW_REQ, 13'd0, REQ_FREE, 12'hAAA, 1'b1, 1'b0, 1'b1, '{ST_DONE, 1'b0, 1'b0, 1'b0, 12'd0}},
      '{ROW_REQ, 13'd0, REQ_FREE, 12'h555, 1'b0, 1'b1, 1'b1, '{ST_DONE, 1'b0, 1'b0, 1'b0, 12'd0}},
      '{ROW_REQ, 13'd0, REQ_ALLOC, 12'h800, 1'b1, 1'b0, 1'b1,
        '{ST_NOTHING, 1'b0, 1'b0, 1'b0, 12'h800}},
      '{ROW_CSR, 13'd0, REQ_ALLOC, 12'd0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_REQ, 13'd0, REQ_ALLOC, 12'd0, 1'b1, 1'b1, 1'b1,
        '{ST_NO_FREE, 1'b0, 1'b0, 1'b0, 12'd0}},
      '{ROW_REQ, 13'd0, REQ_FREE, 12'd1, 1'b0, 1'b0, 1'b1, '{ST_RANGE, 1'b0, 1'b0, 1'b0, 12'd1}},
      '{ROW_REQ, 13'd0, REQ_FREE, 12'd4095, 1'b1, 1'b1, 1'b1,
        '{ST_RANGE, 1'b0, 1'b0, 1'b0, 12'd4095}},
      // count above the frame total saturates
      '{ROW_CSR, 13'd8191, REQ_ALLOC, 12'd0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_REQ, 13'd0, REQ_FREE, 12'd4095, 1'b0, 1'b0, 1'b1,
        '{ST_DONE, 1'b0, 1'b0, 1'b0, 12'd0}},
      '{ROW_REQ, 13'd0, REQ_ALLOC, 12'd0, 1'b0, 1'b1, 1'b0, '0},
      // partial last word: freeable but never scanned
      '{ROW_CSR, 13'd33, REQ_ALLOC, 12'd0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_REQ, 13'd0, REQ_FREE, 12'd32, 1'b1, 1'b0, 1'b1, '{ST_DONE, 1'b0, 1'b0, 1'b0, 12'd0}},
      '{ROW_REQ, 13'd0, REQ_FREE, 12'd33, 1'b0, 1'b1, 1'b1, '{ST_RANGE, 1'b0, 1'b0, 1'b0, 12'd33}},
      '{ROW_REQ, 13'd0, REQ_ALLOC, 12'd0, 1'b1, 1'b1, 1'b0, '0},
      '{ROW_CSR, 13'd32, REQ_ALLOC, 12'd0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_REQ, 13'd0, REQ_FREE, 12'd32, 1'b0, 1'b0, 1'b1, '{ST_RANGE, 1'b0, 1'b0, 1'b0, 12'd32}},
      '{ROW_CSR, 13'd4096, REQ_ALLOC, 12'd0, 1'b0, 1'b0, 1'b0, '0}
   };

   phase_type phases [N_PHASES] = '{
      '{13'd64,   22, 80, 130, 65},
      '{13'd100,  22, 80, 100, 40},
      '{13'd4096, 80, 22,  90, 55},
      '{13'd33,   80, 22, 100, 60},
      '{13'd8191,  0,  0,  80, 50},
      '{13'd96,    0,  0, 150, 60}
   };

   frame_bitmap_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Work out the page entry the block returns, and update the bitmap.
   task automatic compute_page_entry(input req_kind_type kind, input logic [FRAME_W-1:0] frame,
                                     input logic kern, input logic wr,
                                     output page_entry_type entry);
      int limit;
      int scan_top;
      int found;
      limit = (frames_setting > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES : int'(frames_setting);
      entry = '0;
      entry.frame = frame;
      entry.status = ST_DONE;
      if (kind == REQ_ALLOC) begin
         if (frame != 0) begin
            entry.status = ST_NOTHING;
         end else begin
            found = -1;
            scan_top = (limit / WORD_BITS) * WORD_BITS;
            for (int f = 0; f < scan_top && found < 0; f++)
               if (!frame_used[f]) found = f;
            if (found < 0) begin
               entry.frame = '0;
               entry.status = ST_NO_FREE;
            end else begin
               frame_used[found] = 1'b1;
               entry.frame = FRAME_W'(found);
               entry.present = 1'b1;
               entry.rw = wr;
               entry.user = !kern;
               held_frames.push_back(FRAME_W'(found));
            end
         end
      end else if (frame == 0) begin
         entry.status = ST_NOTHING;
      end else if (frame >= limit) begin
         entry.status = ST_RANGE;
      end else begin
         frame_used[frame] = 1'b0;
         entry.frame = '0;
         for (int i = held_frames.size() - 1; i >= 0; i--)
            if (held_frames[i] == frame) held_frames.delete(i);
      end
      status_seen[entry.status]++;
   endtask

   // Hold valid until the beat is taken, then queue what should come back.
   task automatic offer_request(input req_kind_type kind, input logic [FRAME_W-1:0] frame,
                                input logic kern, input logic wr, input logic known,
                                input page_entry_type typed_entry);
      page_entry_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'({wr, kern, frame});
      do @(posedge clock); while (!req_tready);
      compute_page_entry(kind, frame, kern, wr, predicted);
      awaited_entries.push_back(known ? typed_entry : predicted);
      requests_sent++;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_entries.size() != 0);
   endtask

   task automatic set_frame_count(input logic [CFG_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      frames_setting = value;
      settings_used++;
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      page_entry_type got;
      page_entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = page_entry_type'(rsp_tdata[16:0]);
         if (awaited_entries.size() == 0) begin
            $error("result beat with no request outstanding: rsp_tdata %h", rsp_tdata);
            mismatches++;
         end else begin
            want = awaited_entries.pop_front();
            if (got.frame !== want.frame) begin
               $error("granted_frame: expected %0d, got %0d", want.frame, got.frame);
               mismatches++;
            end
            if (got.present !== want.present) begin
               $error("present_bit: expected %0b, got %0b", want.present, got.present);
               mismatches++;
            end
            if (got.rw !== want.rw) begin
               $error("rw_bit: expected %0b, got %0b", want.rw, got.rw);
               mismatches++;
            end
            if (got.user !== want.user) begin
               $error("user_bit: expected %0b, got %0b", want.user, got.user);
               mismatches++;
            end
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               mismatches++;
            end
         end
      end
   end

   // stop a hung run: count cycles in which no beat moves on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no beat for %0d cycles", idle_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [FRAME_W-1:0] frame;
      req_kind_type       kind;
      int                 sel;
      int                 limit;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      hold_request = 1'b0;
      requests_sent = 0;
      settings_used = 0;
      status_seen = '{0, 0, 0, 0};
      frames_setting = CFG_RESET;
      foreach (frame_used[i]) frame_used[i] = 1'b0;
      send_idle_pct = 22;
      recv_idle_pct = 80;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_CSR)
            set_frame_count(dir_rows[r].csr_value);
         else
            offer_request(dir_rows[r].req, dir_rows[r].frame, dir_rows[r].kern, dir_rows[r].wr,
                          dir_rows[r].known, dir_rows[r].typed_entry);
      end

      foreach (phases[p]) begin
         set_frame_count(phases[p].frames);
         send_idle_pct = phases[p].send_idle;
         recv_idle_pct = phases[p].recv_idle;
         limit = (frames_setting > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES : int'(frames_setting);
         for (int n = 0; n < phases[p].items; n++) begin
            // back up the output while requests keep coming
            if (p == 0 && n == 40) hold_request = 1'b1;
            if (p == 2 && n == 45) drain_results();
            sel = $urandom_range(99);
            if (sel < phases[p].alloc_pct || (sel < 85 && held_frames.size() == 0)) begin
               offer_request(REQ_ALLOC, '0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'b0, '0);
            end else if (sel < 85) begin
               frame = held_frames[$urandom_range(held_frames.size() - 1)];
               offer_request(REQ_FREE, frame, 1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'b0, '0);
            end else begin
               kind = req_kind_type'($urandom_range(1));
               case ($urandom_range(3))
                  0: frame = '0;
                  1: frame = FRAME_W'($urandom_range(4095));
                  2: frame = FRAME_W'(limit + $urandom_range(2) - 1);
                  default: frame = FRAME_W'($urandom_range(255));
               endcase
               offer_request(kind, frame, 1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'b0, '0);
            end
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d requests over %0d frame-count settings, stalls on both sides.",
               requests_sent, settings_used);
      $display("Outcomes: %0d done, %0d mapped/nothing, %0d no free frame, %0d out of range.",
               status_seen[ST_DONE], status_seen[ST_NOTHING], status_seen[ST_NO_FREE],
               status_seen[ST_RANGE]);
      if (mismatches == 0 && awaited_entries.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> filelist.f
design/fba_pkg.sv
design/frame_bitmap_allocator.sv
design/fba_checker.sv
tb/sv/testbench.sv
